>>> rtl/m4cm_pkg.sv
// m4cm_pkg: shared types, widths and codes for the 4x4 column multiplier
// no dependencies; imported by every module of the block
`default_nettype none

package m4cm_pkg;

  // fixed point format and datapath widths
  localparam int FRAC_BITS = 16;
  localparam int DIM       = 4;
  localparam int ENTRIES   = DIM * DIM;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int PAIR_W    = PROD_W + 1;
  localparam int SUM_W     = PROD_W + 2;
  localparam int COL_W     = 2;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef word_t mat_t      [ENTRIES];
  typedef word_t vec_t      [DIM];
  typedef prod_t prod_arr_t [ENTRIES];
  typedef pair_t pair_arr_t [2*DIM];
  typedef sum_t  sum_arr_t  [DIM];

  // saturation limits
  localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // request kinds
  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_MULT = 1'b1
  } action_t;

  // control that travels with each pipeline stage
  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] col;
  } pipe_ctl_t;

endpackage

`default_nettype wire

>>> rtl/m4cm_store.sv
// m4cm_store: register store for matrix A, 16 words, column-major
// depends on m4cm_pkg; written one column per load request
`default_nettype none

module m4cm_store (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      wr_en,
  input  wire logic [m4cm_pkg::COL_W-1:0] wr_col,
  input  wire m4cm_pkg::vec_t            wr_data,
  output m4cm_pkg::mat_t                 a_store
);
  import m4cm_pkg::*;

  mat_t store;

  // column write, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        store[i] <= '0;
      end
    end else if (wr_en) begin
      for (int r = 0; r < DIM; r++) begin
        store[{wr_col, COL_W'(r)}] <= wr_data[r];
      end
    end
  end

  assign a_store = store;

endmodule

`default_nettype wire

>>> rtl/m4cm_mul.sv
// m4cm_mul: first pipeline stage, sixteen 32x32 signed products
// depends on m4cm_pkg; reads the A store at request time
`default_nettype none

module m4cm_mul (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire m4cm_pkg::pipe_ctl_t        ctl_in,
  input  wire m4cm_pkg::mat_t             a_store,
  input  wire m4cm_pkg::vec_t             b_col,
  output m4cm_pkg::pipe_ctl_t             ctl_out,
  output m4cm_pkg::prod_arr_t             prod
);
  import m4cm_pkg::*;

  pipe_ctl_t ctl;
  prod_arr_t prod_reg;

  // control register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_in;
    end
  end

  // products, indexed row*4 + k: A(row, col k) times b[k]
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < DIM; r++) begin
        for (int k = 0; k < DIM; k++) begin
          prod_reg[r*DIM + k] <= prod_t'(a_store[k*DIM + r]) * prod_t'(b_col[k]);
        end
      end
    end
  end

  assign ctl_out = ctl;
  assign prod    = prod_reg;

endmodule

`default_nettype wire

>>> rtl/m4cm_add.sv
// m4cm_add: second and third pipeline stages, pairwise then final row sums
// depends on m4cm_pkg; fed by m4cm_mul
`default_nettype none

module m4cm_add (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire m4cm_pkg::pipe_ctl_t  ctl_in,
  input  wire m4cm_pkg::prod_arr_t  prod,
  output m4cm_pkg::pipe_ctl_t       ctl_out,
  output m4cm_pkg::sum_arr_t        sum
);
  import m4cm_pkg::*;

  pipe_ctl_t ctl_pair;
  pipe_ctl_t ctl_sum;
  pair_arr_t pair;
  sum_arr_t  sum_reg;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_pair <= '0;
      ctl_sum  <= '0;
    end else if (en) begin
      ctl_pair <= ctl_in;
      ctl_sum  <= ctl_pair;
    end
  end

  // pair sums: products 0+1 and 2+3 of each row
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < DIM; r++) begin
        pair[2*r]     <= pair_t'(prod[r*DIM])     + pair_t'(prod[r*DIM + 1]);
        pair[2*r + 1] <= pair_t'(prod[r*DIM + 2]) + pair_t'(prod[r*DIM + 3]);
      end
    end
  end

  // full exact row sums
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < DIM; r++) begin
        sum_reg[r] <= sum_t'(pair[2*r]) + sum_t'(pair[2*r + 1]);
      end
    end
  end

  assign ctl_out = ctl_sum;
  assign sum     = sum_reg;

endmodule

`default_nettype wire

>>> rtl/m4cm_sat.sv
// m4cm_sat: last pipeline stage, floor shift by FRAC_BITS and 32-bit saturation
// depends on m4cm_pkg; holds the output registers of the block
`default_nettype none

module m4cm_sat (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire m4cm_pkg::pipe_ctl_t  ctl_in,
  input  wire m4cm_pkg::sum_arr_t   sum,
  output m4cm_pkg::pipe_ctl_t       ctl_out,
  output m4cm_pkg::vec_t            result,
  output logic                      overflow
);
  import m4cm_pkg::*;

  pipe_ctl_t ctl;
  vec_t      result_reg;
  logic      overflow_reg;
  vec_t      result_next;
  logic      overflow_next;

  // arithmetic shift floors; saturate when the high bits are not a sign run
  always_comb begin
    sum_t                      shifted;
    logic [SUM_W-DATA_W:0]     high;
    logic                      row_ovf;
    overflow_next = 1'b0;
    for (int r = 0; r < DIM; r++) begin
      shifted = sum[r] >>> FRAC_BITS;
      high    = shifted[SUM_W-1:DATA_W-1];
      row_ovf = (high != '0) && (high != '1);
      if (row_ovf) begin
        result_next[r] = shifted[SUM_W-1] ? WORD_MIN : WORD_MAX;
      end else begin
        result_next[r] = shifted[DATA_W-1:0];
      end
      overflow_next = overflow_next | row_ovf;
    end
  end

  // output control
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_in;
    end
  end

  // output data
  always_ff @(posedge clk) begin
    if (en) begin
      result_reg   <= result_next;
      overflow_reg <= overflow_next;
    end
  end

  assign ctl_out  = ctl;
  assign result   = result_reg;
  assign overflow = overflow_reg;

endmodule

`default_nettype wire

>>> rtl/matrix4_column_multiply.sv
// matrix4_column_multiply: stored 4x4 Q16.16 matrix A times streamed columns of B
// an accepted multiply request moves through the register stages listed below to its result on the outputs
// throughput: one request per cycle; the four register stages (multiply, pair add,
// row add, shift and saturate) advance together whenever the output is empty or taken
// load requests update the A store at acceptance and produce no result
// reset (synchronous) clears the A store to zeros and empties the pipeline
`default_nettype none

module matrix4_column_multiply (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        action,
  input  wire logic [m4cm_pkg::COL_W-1:0]  column_index,
  input  wire m4cm_pkg::word_t             value0,
  input  wire m4cm_pkg::word_t             value1,
  input  wire m4cm_pkg::word_t             value2,
  input  wire m4cm_pkg::word_t             value3,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [m4cm_pkg::COL_W-1:0]       result_column,
  output m4cm_pkg::word_t                  sum0,
  output m4cm_pkg::word_t                  sum1,
  output m4cm_pkg::word_t                  sum2,
  output m4cm_pkg::word_t                  sum3,
  output logic                             overflow
);
  import m4cm_pkg::*;

  logic      en;
  logic      accept;
  vec_t      b_col;
  mat_t      a_store;
  pipe_ctl_t ctl_in;
  pipe_ctl_t ctl_mul;
  pipe_ctl_t ctl_add;
  pipe_ctl_t ctl_out;
  prod_arr_t prod;
  sum_arr_t  sum;
  vec_t      result;

  // whole pipeline moves when the output register is free or being drained
  assign en       = !ctl_out.valid || out_ready;
  assign in_ready = en;
  assign accept   = in_valid && in_ready;

  assign b_col[0] = value0;
  assign b_col[1] = value1;
  assign b_col[2] = value2;
  assign b_col[3] = value3;

  // only multiply requests enter the pipeline
  assign ctl_in.valid = accept && (action_t'(action) == ACT_MULT);
  assign ctl_in.col   = column_index;

  m4cm_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && (action_t'(action) == ACT_LOAD)),
    .wr_col  (column_index),
    .wr_data (b_col),
    .a_store (a_store)
  );

  m4cm_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (ctl_in),
    .a_store (a_store),
    .b_col   (b_col),
    .ctl_out (ctl_mul),
    .prod    (prod)
  );

  m4cm_add u_add (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (ctl_mul),
    .prod    (prod),
    .ctl_out (ctl_add),
    .sum     (sum)
  );

  m4cm_sat u_sat (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ctl_in   (ctl_add),
    .sum      (sum),
    .ctl_out  (ctl_out),
    .result   (result),
    .overflow (overflow)
  );

  assign out_valid     = ctl_out.valid;
  assign result_column = ctl_out.col;
  assign sum0          = result[0];
  assign sum1          = result[1];
  assign sum2          = result[2];
  assign sum3          = result[3];

endmodule

`default_nettype wire

>>> rtl/m4cm_checker.sv
// m4cm_checker: port-level assertions for matrix4_column_multiply
// depends on m4cm_pkg; attached to the top level by the bind below
`default_nettype none

module m4cm_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        action,
  input wire logic [m4cm_pkg::COL_W-1:0]  column_index,
  input wire m4cm_pkg::word_t             value0,
  input wire m4cm_pkg::word_t             value1,
  input wire m4cm_pkg::word_t             value2,
  input wire m4cm_pkg::word_t             value3,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [m4cm_pkg::COL_W-1:0]  result_column,
  input wire m4cm_pkg::word_t             sum0,
  input wire m4cm_pkg::word_t             sum1,
  input wire m4cm_pkg::word_t             sum2,
  input wire m4cm_pkg::word_t             sum3,
  input wire logic                        overflow
);
  import m4cm_pkg::*;

  // pipeline is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result request present right after reset");

  // a waiting input request keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(action) && $stable(column_index)
      && $stable(value0) && $stable(value1) && $stable(value2) && $stable(value3))
    else $error("waiting input request changed");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_column) && $stable(sum0)
      && $stable(sum1) && $stable(sum2) && $stable(sum3) && $stable(overflow))
    else $error("stalled result changed");

  // an empty output stage never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while output is empty");

  // overflow implies at least one sum sits at a saturation limit
  a_ovf_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |->
      sum0 == WORD_MAX || sum0 == WORD_MIN || sum1 == WORD_MAX || sum1 == WORD_MIN ||
      sum2 == WORD_MAX || sum2 == WORD_MIN || sum3 == WORD_MAX || sum3 == WORD_MIN)
    else $error("overflow flag without a saturated sum");

endmodule

bind matrix4_column_multiply m4cm_checker u_m4cm_checker (.*);

`default_nettype wire
